// File: rtl/bibc_pkg.sv
// bibc_pkg: shared types and constants for the binary image box counter
// holds field widths, operation codes, register indexes and the config struct
// depends on nothing
`timescale 1ns / 1ps

package bibc_pkg;

   localparam int ENTRY_W    = 13;   // table entry and result width
   localparam int COORD_W    = 16;   // signed query corner width
   localparam int DIM_W      = 7;    // row count / column count register width
   localparam int CNT_W      = 3;    // image_count register width
   localparam int IMG_FLD_W  = 3;    // image field width
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [CNT_W-1:0] RST_IMAGE_COUNT = 3'd4;
   localparam logic [DIM_W-1:0] RST_IMAGE_DIM   = 7'd64;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_IMAGE_COUNT  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_IMAGE_WIDTH  = 2'd2
   } reg_index_type;

   // effective sizes as seen by the datapath
   typedef struct packed {
      logic [CNT_W-1:0] image_count;   // raw register, limited at the use
      logic [DIM_W-1:0] height;        // saturated into 1..max height
      logic [DIM_W-1:0] width;         // saturated into 1..max width
   } cfg_type;

endpackage

// File: rtl/bibc_csr.sv
// bibc_csr: configuration registers behind the apb-style port
// produces the effective image sizes; depends on bibc_pkg
`timescale 1ns / 1ps

module bibc_csr
   import bibc_pkg::*;
#(
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_WIDTH  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [CNT_W-1:0] image_count_ff, image_count_in;
   logic [DIM_W-1:0] img_rows_ff, img_rows_in;
   logic [DIM_W-1:0] img_cols_ff, img_cols_in;
   logic             wr_en;
   reg_index_type    reg_idx;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                input int unsigned max_v);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (32'(v) > max_v) begin
         return DIM_W'(max_v);
      end
      return v;
   endfunction

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      image_count_in = image_count_ff;
      img_rows_in    = img_rows_ff;
      img_cols_in    = img_cols_ff;
      csr_prdata     = '0;
      case (reg_idx)
         REG_IMAGE_COUNT: begin
            csr_prdata = CSR_DATA_W'(image_count_ff);
            if (wr_en) begin
               image_count_in = csr_pwdata[CNT_W-1:0];
            end
         end
         REG_IMAGE_HEIGHT: begin
            csr_prdata = CSR_DATA_W'(img_rows_ff);
            if (wr_en) begin
               img_rows_in = csr_pwdata[DIM_W-1:0];
            end
         end
         REG_IMAGE_WIDTH: begin
            csr_prdata = CSR_DATA_W'(img_cols_ff);
            if (wr_en) begin
               img_cols_in = csr_pwdata[DIM_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_count_ff <= RST_IMAGE_COUNT;
         img_rows_ff    <= RST_IMAGE_DIM;
         img_cols_ff    <= RST_IMAGE_DIM;
      end else begin
         image_count_ff <= image_count_in;
         img_rows_ff    <= img_rows_in;
         img_cols_ff    <= img_cols_in;
      end
   end

   assign cfg.image_count = image_count_ff;
   assign cfg.height      = eff_dim(img_rows_ff, MAX_HEIGHT);
   assign cfg.width       = eff_dim(img_cols_ff, MAX_WIDTH);

endmodule

// File: rtl/bibc_table.sv
// bibc_table: single-port summed-area table store, one access per cycle
// read data registered, held until the next read; depends on bibc_pkg
`timescale 1ns / 1ps

module bibc_table
   import bibc_pkg::*;
#(
   parameter int ADDR_W = 14
) (
   input  logic               clock,
   input  logic               mem_en,
   input  logic               mem_we,
   input  logic [ADDR_W-1:0]  mem_addr,
   input  logic [ENTRY_W-1:0] mem_wdata,
   output logic [ENTRY_W-1:0] mem_rdata
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_en && mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_en && !mem_we) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// File: rtl/bibc_ctrl.sv
// bibc_ctrl: sequencer for pixel loads and rectangle queries
// drives the table port, keeps the load position and the result register
// depends on bibc_pkg
`timescale 1ns / 1ps

module bibc_ctrl
   import bibc_pkg::*;
#(
   parameter int NUM_IMAGES = 4,
   parameter int MAX_WIDTH  = 64,
   parameter int IMG_W      = 2,
   parameter int ROW_W      = 6,
   parameter int COL_W      = 6,
   parameter int ADDR_W     = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [IMG_FLD_W-1:0]        req_image,
   input  logic                        req_pixel,
   input  logic                        req_first_pixel,
   input  logic signed [COORD_W-1:0]   req_row_low,
   input  logic signed [COORD_W-1:0]   req_col_low,
   input  logic signed [COORD_W-1:0]   req_row_high,
   input  logic signed [COORD_W-1:0]   req_col_high,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ENTRY_W-1:0]          rsp_pixel_count,
   output logic                        mem_en,
   output logic                        mem_we,
   output logic [ADDR_W-1:0]           mem_addr,
   output logic [ENTRY_W-1:0]          mem_wdata,
   input  logic [ENTRY_W-1:0]          mem_rdata
);

   localparam int RUN_W = $clog2(MAX_WIDTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LD_WR  = 5'b00010,
      ST_QUERY  = 5'b00100,
      ST_Q_LAST = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0] rsp_count_ff, rsp_count_in;

   // payload registers of the item in flight
   logic [IMG_W-1:0]   img_ff, img_in;
   logic [ADDR_W-1:0]  ld_addr_ff, ld_addr_in;
   logic [RUN_W-1:0]   ld_run_ff, ld_run_in;
   logic               ld_above_ff, ld_above_in;
   logic [ROW_W-1:0]   r0m1_ff, r0m1_in, r1_ff, r1_in;
   logic [COL_W-1:0]   c0m1_ff, c0m1_in, c1_ff, c1_in;
   logic               r0nz_ff, r0nz_in, c0nz_ff, c0nz_in;
   logic [ENTRY_W-1:0] acc_ff, acc_in;

   logic               accept;
   logic               img_ok;
   logic               restart;
   logic [ROW_W-1:0]   pos_row;
   logic [COL_W-1:0]   pos_col;
   logic [RUN_W-1:0]   run_new;
   logic [ROW_W-1:0]   q_r0, q_r1;
   logic [COL_W-1:0]   q_c0, q_c1;
   logic               inverted;
   logic [3:0]         term_en;
   logic [1:0]         acc_idx;
   logic [ROW_W-1:0]   q_row;
   logic [COL_W-1:0]   q_col;
   logic               out_free;

   function automatic logic [DIM_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] v,
                                                    input logic [DIM_W-1:0] n);
      logic signed [COORD_W-1:0] n_s;
      n_s = signed'(COORD_W'(n));
      if (v < 0) begin
         return '0;
      end
      if (v >= n_s) begin
         return n - DIM_W'(1);
      end
      return DIM_W'(v);
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign img_ok    = (32'(req_image) < 32'(cfg.image_count)) &&
                      (32'(req_image) < NUM_IMAGES);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // load position, restarted on a first pixel or when a size change leaves it outside the image
   assign restart = req_first_pixel || (32'(row_ff) >= 32'(cfg.height)) ||
                    (32'(col_ff) >= 32'(cfg.width));
   assign pos_row = restart ? '0 : row_ff;
   assign pos_col = restart ? '0 : col_ff;
   assign run_new = (restart ? '0 : run_ff) + RUN_W'(req_pixel);

   // clamped query corners
   assign inverted = (req_row_low > req_row_high) || (req_col_low > req_col_high);
   assign q_r0 = ROW_W'(clamp_coord(req_row_low, cfg.height));
   assign q_r1 = ROW_W'(clamp_coord(req_row_high, cfg.height));
   assign q_c0 = COL_W'(clamp_coord(req_col_low, cfg.width));
   assign q_c1 = COL_W'(clamp_coord(req_col_high, cfg.width));

   // corner terms: high/high add, low/low add, low row sub, low col sub
   assign term_en = {c0nz_ff, r0nz_ff, r0nz_ff && c0nz_ff, 1'b1};
   assign acc_idx = (state_ff == ST_Q_LAST) ? 2'd3 : (step_ff - 2'd1);

   always_comb begin
      case (step_ff)
         2'd0: begin
            q_row = r1_ff;
            q_col = c1_ff;
         end
         2'd1: begin
            q_row = r0m1_ff;
            q_col = c0m1_ff;
         end
         2'd2: begin
            q_row = r0m1_ff;
            q_col = c1_ff;
         end
         2'd3: begin
            q_row = r1_ff;
            q_col = c0m1_ff;
         end
         default: begin
            q_row = r1_ff;
            q_col = c1_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      img_in       = img_ff;
      ld_addr_in   = ld_addr_ff;
      ld_run_in    = ld_run_ff;
      ld_above_in  = ld_above_ff;
      r0m1_in      = r0m1_ff;
      r1_in        = r1_ff;
      c0m1_in      = c0m1_ff;
      c1_in        = c1_ff;
      r0nz_in      = r0nz_ff;
      c0nz_in      = c0nz_ff;
      acc_in       = acc_ff;
      mem_en       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = ld_addr_ff;
      mem_wdata    = (ld_above_ff ? mem_rdata : '0) + ENTRY_W'(ld_run_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               img_in = IMG_W'(req_image);
               if (req_op == OP_LOAD) begin
                  if (img_ok) begin
                     ld_addr_in  = {IMG_W'(req_image), pos_row, pos_col};
                     ld_run_in   = run_new;
                     ld_above_in = (pos_row != '0);
                     // fetch the entry one row above
                     mem_en   = (pos_row != '0);
                     mem_addr = {IMG_W'(req_image), pos_row - ROW_W'(1), pos_col};
                     if (32'(pos_col) + 32'd1 >= 32'(cfg.width)) begin
                        col_in = '0;
                        run_in = '0;
                        if (32'(pos_row) + 32'd1 >= 32'(cfg.height)) begin
                           row_in = '0;
                        end else begin
                           row_in = pos_row + ROW_W'(1);
                        end
                     end else begin
                        col_in = pos_col + COL_W'(1);
                        row_in = pos_row;
                        run_in = run_new;
                     end
                     state_in = ST_LD_WR;
                  end
               end else begin
                  acc_in  = '0;
                  r1_in   = q_r1;
                  c1_in   = q_c1;
                  r0m1_in = q_r0 - ROW_W'(1);
                  c0m1_in = q_c0 - COL_W'(1);
                  r0nz_in = (q_r0 != '0);
                  c0nz_in = (q_c0 != '0);
                  step_in = 2'd0;
                  if (!img_ok || inverted) begin
                     state_in = ST_REPLY;
                  end else begin
                     state_in = ST_QUERY;
                  end
               end
            end
         end
         ST_LD_WR: begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_QUERY: begin
            mem_en   = term_en[step_ff];
            mem_addr = {img_ff, q_row, q_col};
            if (step_ff != 2'd0 && term_en[acc_idx]) begin
               acc_in = acc_idx[1] ? (acc_ff - mem_rdata) : (acc_ff + mem_rdata);
            end
            if (step_ff == 2'd3) begin
               state_in = ST_Q_LAST;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_Q_LAST: begin
            if (term_en[acc_idx]) begin
               acc_in = acc_idx[1] ? (acc_ff - mem_rdata) : (acc_ff + mem_rdata);
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      img_ff       <= img_in;
      ld_addr_ff   <= ld_addr_in;
      ld_run_ff    <= ld_run_in;
      ld_above_ff  <= ld_above_in;
      r0m1_ff      <= r0m1_in;
      r1_ff        <= r1_in;
      c0m1_ff      <= c0m1_in;
      c1_ff        <= c1_in;
      r0nz_ff      <= r0nz_in;
      c0nz_ff      <= c0nz_in;
      acc_ff       <= acc_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_count = rsp_count_ff;

endmodule

// File: rtl/binary_image_box_count.sv
// binary_image_box_count: top level of the summed-area table box counter
// ties together bibc_csr, bibc_table and bibc_ctrl; depends on bibc_pkg
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   req     | in        | req_valid/req_stall | op, image, pixel, first_pixel, four corners
//   rsp     | out       | rsp_valid/rsp_stall | pixel_count (one per query, none per load)
//   csr     | in        | apb-style, pready=1 | image count, rows, columns
//
// a load transaction reads the entry one row above, if any, in the accept cycle and
// writes the new entry in the next cycle. a query goes through accept, four table
// slots for the corner reads, the last add, then the hand-over to the output register;
// one for an image out of range or with inverted corners skips the reads.
// the single port of the table forces this order; a full output register holds the hand-over.
// reset is synchronous and active high; the table itself is not cleared, so there is
// no clearing pass. a stalled result waits in the output register.
`timescale 1ns / 1ps

module binary_image_box_count
   import bibc_pkg::*;
#(
   parameter int NUM_IMAGES = 4,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_WIDTH  = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // request transactions
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic [IMG_FLD_W-1:0]      req_image,
   input  logic                      req_pixel,
   input  logic                      req_first_pixel,
   input  logic signed [COORD_W-1:0] req_row_low,
   input  logic signed [COORD_W-1:0] req_col_low,
   input  logic signed [COORD_W-1:0] req_row_high,
   input  logic signed [COORD_W-1:0] req_col_high,
   // result transactions
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ENTRY_W-1:0]        rsp_pixel_count,
   // configuration
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   // table address is {image, row, column}
   localparam int IMG_W  = (NUM_IMAGES > 1) ? $clog2(NUM_IMAGES) : 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ADDR_W = IMG_W + ROW_W + COL_W;

   cfg_type            cfg;
   logic               mem_en;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ENTRY_W-1:0] mem_rdata;

   // register file, also saturates the image sizes
   bibc_csr #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // summed-area entries of all images
   bibc_table #(
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock     (clock),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // one transaction at a time: read-modify-write for loads, up to four reads for queries
   bibc_ctrl #(
      .NUM_IMAGES (NUM_IMAGES),
      .MAX_WIDTH  (MAX_WIDTH),
      .IMG_W      (IMG_W),
      .ROW_W      (ROW_W),
      .COL_W      (COL_W),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_image       (req_image),
      .req_pixel       (req_pixel),
      .req_first_pixel (req_first_pixel),
      .req_row_low     (req_row_low),
      .req_col_low     (req_col_low),
      .req_row_high    (req_row_high),
      .req_col_high    (req_col_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_count (rsp_pixel_count),
      .mem_en          (mem_en),
      .mem_we          (mem_we),
      .mem_addr        (mem_addr),
      .mem_wdata       (mem_wdata),
      .mem_rdata       (mem_rdata)
   );

   // a query always occupies the sequencer for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op == OP_QUERY) |=> req_stall)
      else $error("query accepted but sequencer not busy");

   // table writes only follow directly on an accepted load
   assert property (@(posedge clock) disable iff (reset)
      (mem_en && mem_we) |-> $past(req_valid && !req_stall && req_op == OP_LOAD))
      else $error("table write without a preceding load");

   // a new result only comes out of a busy sequencer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

endmodule

// File: tb/sv/testbench.sv
// testbench for binary_image_box_count: loads small silhouettes pixel by pixel, asks box counts
// and compares every pixel_count against a running summed-area table kept here
// depends on bibc_pkg and the rtl of binary_image_box_count
`timescale 1ns / 1ps

module testbench;
   import bibc_pkg::*;

   localparam int NUM_IMG       = 4;
   localparam int MAX_H         = 64;
   localparam int MAX_W         = 64;
   localparam int SETTLE_CYCLES = 20;          // margin after the owed counts are back
   localparam int RUN_LIMIT_NS  = 5_000_000;   // far beyond the slowest run

   // one request transaction, don't-care fields included
   typedef struct {
      op_type                    op;
      logic [IMG_FLD_W-1:0]      image;
      logic                      pixel;
      logic                      first_pixel;
      logic signed [COORD_W-1:0] row_low;
      logic signed [COORD_W-1:0] col_low;
      logic signed [COORD_W-1:0] row_high;
      logic signed [COORD_W-1:0] col_high;
   } box_request_type;

   // running copy of the tables, the load position and the sizes in use;
   // holds the pixel counts still owed by the block
   class box_tally_type;
      logic [ENTRY_W-1:0] area   [NUM_IMG][MAX_H][MAX_W];
      bit                 filled [NUM_IMG][MAX_H][MAX_W];
      int unsigned        row_pos, col_pos, run_count;
      int unsigned        img_limit, rows, cols;
      logic [ENTRY_W-1:0] owed_counts [$];
      int unsigned        failures, checked, loads, queries;

      function new();
         row_pos   = 0;
         col_pos   = 0;
         run_count = 0;
         img_limit = 32'(RST_IMAGE_COUNT);
         rows      = 32'(RST_IMAGE_DIM);
         cols      = 32'(RST_IMAGE_DIM);
         failures  = 0;
         checked   = 0;
         loads     = 0;
         queries   = 0;
      endfunction

      function int unsigned fit_dim(int unsigned v, int unsigned top);
         if (v < 1) return 1;
         return (v > top) ? top : v;
      endfunction

      function int unsigned clamp_to(logic signed [COORD_W-1:0] v, int unsigned n);
         if (v < 0) return 0;
         if (int'(v) >= int'(n)) return n - 1;
         return int'(v);
      endfunction

      function void apply_setting(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_IMAGE_COUNT: begin
               img_limit = (32'(value[CNT_W-1:0]) > NUM_IMG) ? NUM_IMG
                                                               : 32'(value[CNT_W-1:0]);
            end
            REG_IMAGE_HEIGHT: rows = fit_dim(32'(value[DIM_W-1:0]), MAX_H);
            REG_IMAGE_WIDTH:  cols = fit_dim(32'(value[DIM_W-1:0]), MAX_W);
            default: ;
         endcase
      endfunction

      function bit ignored(box_request_type it);
         return it.op == OP_LOAD && it.image >= img_limit;
      endfunction

      // a load on any row but row 0 reads the entry above, which must exist
      function bit load_reads_blank(box_request_type it);
         int unsigned r, c;
         if (it.op != OP_LOAD || it.image >= img_limit) return 0;
         if (it.first_pixel || row_pos >= rows || col_pos >= cols) return 0;
         r = row_pos;
         c = col_pos;
         return r > 0 && !filled[it.image][r-1][c];
      endfunction

      // same entry set as the inclusion-exclusion below
      function bit query_reads_blank(box_request_type it);
         int unsigned r0, c0, r1, c1;
         if (it.image >= img_limit) return 0;
         if (it.row_low > it.row_high || it.col_low > it.col_high) return 0;
         r0 = clamp_to(it.row_low, rows);
         c0 = clamp_to(it.col_low, cols);
         r1 = clamp_to(it.row_high, rows);
         c1 = clamp_to(it.col_high, cols);
         if (!filled[it.image][r1][c1]) return 1;
         if (r0 > 0 && c0 > 0 && !filled[it.image][r0-1][c0-1]) return 1;
         if (r0 > 0 && !filled[it.image][r0-1][c1]) return 1;
         if (c0 > 0 && !filled[it.image][r1][c0-1]) return 1;
         return 0;
      endfunction

      function void note_request(box_request_type it);
         logic [ENTRY_W-1:0] above, total;
         int unsigned        r0, c0, r1, c1;
         if (it.op == OP_LOAD) begin
            if (it.image >= img_limit) return;
            loads++;
            if (it.first_pixel || row_pos >= rows || col_pos >= cols) begin
               row_pos   = 0;
               col_pos   = 0;
               run_count = 0;
            end
            run_count += 32'(it.pixel);
            above = (row_pos > 0) ? area[it.image][row_pos-1][col_pos] : '0;
            area[it.image][row_pos][col_pos]   = above + ENTRY_W'(run_count);
            filled[it.image][row_pos][col_pos] = 1'b1;
            col_pos++;
            if (col_pos >= cols) begin
               col_pos   = 0;
               run_count = 0;
               row_pos++;
               if (row_pos >= rows) row_pos = 0;
            end
            return;
         end
         queries++;
         if (it.image >= img_limit || it.row_low > it.row_high || it.col_low > it.col_high) begin
            owed_counts.push_back('0);
            return;
         end
         r0 = clamp_to(it.row_low, rows);
         c0 = clamp_to(it.col_low, cols);
         r1 = clamp_to(it.row_high, rows);
         c1 = clamp_to(it.col_high, cols);
         total = area[it.image][r1][c1];
         if (r0 > 0 && c0 > 0) total += area[it.image][r0-1][c0-1];
         if (r0 > 0) total -= area[it.image][r0-1][c1];
         if (c0 > 0) total -= area[it.image][r1][c0-1];
         owed_counts.push_back(total);
      endfunction

      function void check_count(logic [ENTRY_W-1:0] got);
         logic [ENTRY_W-1:0] want;
         if (owed_counts.size() == 0) begin
            failures++;
            $error("pixel_count: expected none, actual %0d", got);
            return;
         end
         want = owed_counts.pop_front();
         checked++;
         if (got !== want) begin
            failures++;
            $error("pixel_count: expected %0d, actual %0d", want, got);
         end
      endfunction

      function int unsigned pending();
         return owed_counts.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_op = 1'b0;
   logic [IMG_FLD_W-1:0]      req_image = '0;
   logic                      req_pixel = 1'b0;
   logic                      req_first_pixel = 1'b0;
   logic signed [COORD_W-1:0] req_row_low = '0;
   logic signed [COORD_W-1:0] req_col_low = '0;
   logic signed [COORD_W-1:0] req_row_high = '0;
   logic signed [COORD_W-1:0] req_col_high = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [ENTRY_W-1:0]        rsp_pixel_count;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   box_tally_type board = new();
   int unsigned gap_pct = 0;      // chance of a sender pause before a transaction
   int unsigned stall_pct = 0;    // chance of a receiver stall burst starting
   bit          quiet = 0;        // closing stretch: no idling at all
   int unsigned stall_left = 0;
   int unsigned setting_total = 0;

   binary_image_box_count #(
      .NUM_IMAGES (NUM_IMG),
      .MAX_HEIGHT (MAX_H),
      .MAX_WIDTH  (MAX_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_image       (req_image),
      .req_pixel       (req_pixel),
      .req_first_pixel (req_first_pixel),
      .req_row_low     (req_row_low),
      .req_col_low     (req_col_low),
      .req_row_high    (req_row_high),
      .req_col_high    (req_col_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_count (rsp_pixel_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // receiver: random stall bursts, never in the closing stretch
   always @(posedge clock) begin
      if (quiet) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
         stall_left = $urandom_range(1, 17);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // every accepted result transaction is checked against the oldest owed count
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_count(rsp_pixel_count);
   end

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("testbench: FAIL");
      $finish;
   end

   function automatic box_request_type random_fill();
      box_request_type it;
      it.op          = op_type'($urandom_range(0, 1));
      it.image       = IMG_FLD_W'($urandom_range(0, 7));
      it.pixel       = 1'($urandom_range(0, 1));
      it.first_pixel = 1'($urandom_range(0, 1));
      it.row_low     = COORD_W'($urandom());
      it.col_low     = COORD_W'($urandom());
      it.row_high    = COORD_W'($urandom());
      it.col_high    = COORD_W'($urandom());
      return it;
   endfunction

   function automatic box_request_type make_item(op_type op, logic [IMG_FLD_W-1:0] image,
                                                 logic pixel, logic first_pixel,
                                                 logic signed [COORD_W-1:0] row_low,
                                                 logic signed [COORD_W-1:0] col_low,
                                                 logic signed [COORD_W-1:0] row_high,
                                                 logic signed [COORD_W-1:0] col_high);
      box_request_type it;
      it.op          = op;
      it.image       = image;
      it.pixel       = pixel;
      it.first_pixel = first_pixel;
      it.row_low     = row_low;
      it.col_low     = col_low;
      it.row_high    = row_high;
      it.col_high    = col_high;
      return it;
   endfunction

   // mostly just around the image, now and then the extremes or anything at all
   function automatic logic signed [COORD_W-1:0] pick_corner(int unsigned span);
      int unsigned sel;
      sel = $urandom_range(0, 11);
      if (sel == 0) return 16'sh8000;
      if (sel == 1) return 16'sh7fff;
      if (sel == 2) return COORD_W'($urandom());
      return COORD_W'($urandom_range(0, span + 3)) - 16'sd2;
   endfunction

   // one request transaction; valid stays high between back-to-back transactions
   task automatic send_item(input box_request_type it);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= it.op;
      req_image       <= it.image;
      req_pixel       <= it.pixel;
      req_first_pixel <= it.first_pixel;
      req_row_low     <= it.row_low;
      req_col_low     <= it.col_low;
      req_row_high    <= it.row_high;
      req_col_high    <= it.col_high;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(it);
   endtask

   // sender holds off until every owed count is back and the last load has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.apply_setting(idx, value);
      @(posedge clock);
   endtask

   // one register setting, then a mix of raster loads, box queries and noise
   task automatic run_phase(input logic [CSR_DATA_W-1:0] count_val,
                            input logic [CSR_DATA_W-1:0] height_val,
                            input logic [CSR_DATA_W-1:0] width_val,
                            input int unsigned budget);
      box_request_type           it;
      int unsigned               issued, pixels_left, density, pick, tries;
      logic [IMG_FLD_W-1:0]      cur_img;
      logic signed [COORD_W-1:0] a, b;
      bit                        ready, opening;
      drain();
      write_setting(REG_IMAGE_COUNT, count_val);
      write_setting(REG_IMAGE_HEIGHT, height_val);
      write_setting(REG_IMAGE_WIDTH, width_val);
      setting_total++;
      issued      = 0;
      pixels_left = 0;
      density     = 50;
      cur_img     = '0;
      opening     = 1;
      while (issued < budget) begin
         it    = random_fill();
         ready = 1;
         pick  = $urandom_range(0, 99);
         if (pick < 55 && board.img_limit != 0) begin
            // raster load of the image in progress
            it.op = OP_LOAD;
            if (pixels_left == 0) begin
               cur_img     = IMG_FLD_W'($urandom_range(0, board.img_limit - 1));
               pixels_left = board.rows * board.cols;
               case ($urandom_range(0, 4))
                  0:       density = 0;
                  1:       density = 100;
                  default: density = $urandom_range(10, 90);
               endcase
               it.first_pixel = ($urandom_range(0, 3) != 0);
            end else begin
               it.first_pixel = 1'b0;
            end
            // first load after a size change continues from the old position
            if (opening) it.first_pixel = 1'b0;
            it.image = cur_img;
            it.pixel = ($urandom_range(0, 99) < density);
            if (board.load_reads_blank(it)) begin
               it.first_pixel = 1'b1;
               pixels_left    = board.rows * board.cols;
            end
            pixels_left--;
            opening = 0;
         end else if (pick < 85) begin
            // ordered box on a loaded image, redrawn while it would touch empty entries
            it.op = OP_QUERY;
            if (board.img_limit == 0) it.image = IMG_FLD_W'($urandom_range(0, 7));
            else it.image = IMG_FLD_W'($urandom_range(0, board.img_limit - 1));
            tries = 0;
            do begin
               a = pick_corner(board.rows);
               b = pick_corner(board.rows);
               it.row_low  = (a > b) ? b : a;
               it.row_high = (a > b) ? a : b;
               a = pick_corner(board.cols);
               b = pick_corner(board.cols);
               it.col_low  = (a > b) ? b : a;
               it.col_high = (a > b) ? a : b;
               tries++;
            end while (board.query_reads_blank(it) && tries < 8);
            if (board.query_reads_blank(it))
               it.image = IMG_FLD_W'($urandom_range(board.img_limit, 7));
         end else if (pick < 90) begin
            // image out of range, or corners the wrong way round
            it.op = OP_QUERY;
            if ($urandom_range(0, 1)) begin
               it.image = IMG_FLD_W'($urandom_range(board.img_limit, 7));
            end else begin
               a = pick_corner(board.rows);
               b = pick_corner(board.rows);
               if (a == b) b = a ^ 16'h1;
               tries = $urandom_range(0, 2);
               if (tries != 1) begin
                  it.row_low  = (a > b) ? a : b;
                  it.row_high = (a > b) ? b : a;
               end
               if (tries != 0) begin
                  it.col_low  = (a > b) ? a : b;
                  it.col_high = (a > b) ? b : a;
               end
            end
         end else if (pick < 95) begin
            // stray load: any image, sometimes a restart in the middle of a raster
            it.op          = OP_LOAD;
            it.first_pixel = ($urandom_range(0, 7) == 0);
            if (board.load_reads_blank(it)) it.first_pixel = 1'b1;
         end else begin
            // anything at all, kept only if every entry it reads is there
            it.op = OP_QUERY;
            if (board.query_reads_blank(it)) ready = 0;
         end
         if (ready) begin
            if (!board.ignored(it)) issued++;
            send_item(it);
         end
      end
   endtask

   initial begin
      logic pattern [6];
      pattern = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset sizes: nothing loaded yet, so only trivial queries
      gap_pct   = 10;
      stall_pct = 10;
      send_item(make_item(OP_QUERY, 3'd4, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
      send_item(make_item(OP_QUERY, 3'd0, 1'b1, 1'b1, 16'sd5, 16'sd0, 16'sd3, 16'sd0));
      send_item(make_item(OP_LOAD, 3'd5, 1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
      send_item(make_item(OP_QUERY, 3'd7, 1'b0, 1'b0,
                          16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff));

      // 2 x 3 images: a known pattern in image 0, all set in image 1
      drain();
      write_setting(REG_IMAGE_COUNT, 32'd4);
      write_setting(REG_IMAGE_HEIGHT, 32'd2);
      write_setting(REG_IMAGE_WIDTH, 32'd3);
      setting_total++;
      foreach (pattern[i]) begin
         // a load to an image out of range in the middle of the raster is dropped
         if (i == 3) send_item(make_item(OP_LOAD, 3'd6, 1'b1, 1'b0, '0, '0, '0, '0));
         send_item(make_item(OP_LOAD, 3'd0, pattern[i], i == 0, '0, '0, '0, '0));
      end
      // position wrapped to the origin, so no restart flag is needed
      repeat (6) send_item(make_item(OP_LOAD, 3'd1, 1'b1, 1'b0, '0, '0, '0, '0));
      send_item(make_item(OP_QUERY, 3'd0, 1'b0, 1'b0,
                          16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff));
      send_item(make_item(OP_QUERY, 3'd0, 1'b0, 1'b0, 16'sd1, 16'sd1, 16'sd1, 16'sd1));
      send_item(make_item(OP_QUERY, 3'd0, 1'b0, 1'b0, 16'sd0, 16'sd1, 16'sd1, 16'sd2));
      send_item(make_item(OP_QUERY, 3'd0, 1'b0, 1'b0, 16'sd1, 16'sd0, 16'sd1, 16'sd2));
      send_item(make_item(OP_QUERY, 3'd1, 1'b0, 1'b0, -16'sd5, -16'sd5, 16'sd9, 16'sd9));
      send_item(make_item(OP_QUERY, 3'd0, 1'b0, 1'b0, 16'sd0, 16'sd3, 16'sd1, 16'sd5));
      send_item(make_item(OP_QUERY, 3'd0, 1'b0, 1'b0, 16'sd0, 16'sd2, 16'sd1, 16'sd1));
      send_item(make_item(OP_QUERY, 3'd4, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd1, 16'sd2));

      // random part: small sizes mostly, the largest only along one axis
      gap_pct   = 8;
      stall_pct = 8;
      run_phase(32'd4, 32'd4, 32'd5, 150);
      gap_pct   = 30;
      stall_pct = 30;
      run_phase(32'd1, 32'd64, 32'd1, 160);
      gap_pct   = 0;
      stall_pct = 0;
      run_phase(32'd2, 32'd1, 32'd127, 160);   // width saturates to the maximum
      gap_pct   = 15;
      stall_pct = 40;
      run_phase(32'd7, 32'd0, 32'd0, 80);      // count limited, sizes forced up to one
      run_phase(32'd0, 32'd3, 32'd3, 40);      // no image in use: every query gives zero
      gap_pct   = 40;
      stall_pct = 10;
      run_phase(32'd3, 32'd2, 32'd64, 200);
      gap_pct   = 10;
      stall_pct = 25;
      run_phase(32'd4, 32'd8, 32'd8, 200);
      gap_pct   = 20;
      stall_pct = 20;
      run_phase($urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(1, 12), 200);
      quiet = 1;
      run_phase(32'd4, 32'd5, 32'd6, 300);

      drain();
      $display("covered %0d pixel loads and %0d box queries over %0d size settings",
               board.loads, board.queries, setting_total);
      $display("%0d pixel counts compared, %0d mismatches", board.checked, board.failures);
      if (board.failures == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule
